// ===== sv/icp_pkg.sv =====
// shared types and constants of the ipv6 cidr text parser
package icp_pkg;

  localparam int unsigned AddrBytes = 16;

  // parse phase codes
  localparam logic [2:0] PH_START       = 3'd0;
  localparam logic [2:0] PH_START_COLON = 3'd1;
  localparam logic [2:0] PH_FIELD       = 3'd2;
  localparam logic [2:0] PH_AFTER_COLON = 3'd3;
  localparam logic [2:0] PH_SLASH       = 3'd4;
  localparam logic [2:0] PH_BITS        = 3'd5;
  localparam logic [2:0] PH_DONE        = 3'd6;

  localparam logic [7:0]  ERR_CODE  = 8'hFF;
  localparam logic [11:0] POS_MAX   = 12'hFFF;
  localparam logic [7:0]  CH_COLON  = 8'h3A;
  localparam logic [7:0]  CH_SLASH  = 8'h2F;
  localparam logic [7:0]  BITS_FULL = 8'd128;
  localparam logic [7:0]  BITS_ONE  = 8'd16;

  // register indexes
  localparam logic REG_ALLOW_TAIL = 1'b0;
  localparam logic REG_CIDR_MODE  = 1'b1;

  typedef struct packed {
    logic allow_tail;
    logic cidr_mode;
  } icp_cfg_t;

  typedef struct packed {
    logic [AddrBytes-1:0][7:0] addr;
    logic [15:0]               field_value;
    logic [2:0]                digit_count;
    logic [4:0]                byte_count;
    logic [4:0]                zr_start;
    logic                      zr_seen;
    logic [2:0]                phase;
    logic [7:0]                suffix;
    logic [11:0]               char_pos;
    logic [11:0]               stop_pos;
    logic [7:0]                prefix_res;
    logic                      tail_present;
  } icp_state_t;

  typedef struct packed {
    logic        error;
    logic [7:0]  prefix_bits;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [11:0] tail_offset;
  } icp_result_t;

  localparam icp_state_t STATE_CLEAR = '{
    addr:         '0,
    field_value:  16'd0,
    digit_count:  3'd0,
    byte_count:   5'd0,
    zr_start:     5'd0,
    zr_seen:      1'b0,
    phase:        PH_START,
    suffix:       8'd0,
    char_pos:     12'd0,
    stop_pos:     12'd0,
    prefix_res:   ERR_CODE,
    tail_present: 1'b0
  };

endpackage

// ===== sv/icp_if.sv =====
// valid/ready channel interfaces for characters in and parse results out
interface icp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_string;

  modport source (output valid, output ch, output end_of_string, input ready);
  modport sink (input valid, input ch, input end_of_string, output ready);
endinterface

interface icp_out_if;
  logic        valid;
  logic        ready;
  logic        error;
  logic [7:0]  prefix_bits;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic [11:0] tail_offset;

  modport source (output valid, output error, output prefix_bits, output addr_high,
                  output addr_low, output tail_offset, input ready);
  modport sink (input valid, input error, input prefix_bits, input addr_high,
                input addr_low, input tail_offset, output ready);
endinterface

// ===== sv/ipv6_cidr_text_parser.sv =====
// top level of the ipv6 address / cidr text parser
// Takes one character per cycle, back to back, on the input channel while
// results are taken; the terminator transfer yields one result on the output
// channel. An accepted character sits in an input register while a single
// step of parse logic updates the parser state; a terminator passes from the
// input register into the result register, so one character per cycle is
// sustained while the output side takes results. A stalled result holds the
// next terminator in the input register, and the characters behind it wait
// too. Address bytes 0 to 15 are packed so that byte 0 is the top of
// addr_high. Registers: allow_tail at 0x0, cidr_mode at 0x4.
module ipv6_cidr_text_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  icp_in_if.sink      in_i,
  icp_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import icp_pkg::*;

  icp_cfg_t    cfg;
  icp_state_t  state_q, state_d;
  icp_result_t res_d, res_q;
  logic        in_valid_q;
  logic [7:0]  ch_q;
  logic        end_q;
  logic        out_valid_q;
  logic        adv;

  icp_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  icp_step u_step (
    .state_i (state_q),
    .ch_i    (ch_q),
    .end_i   (end_q),
    .cfg_i   (cfg),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // a terminator waits only while the result register is still occupied and not taken
  assign adv        = in_valid_q && (!end_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= STATE_CLEAR;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (adv) state_q <= state_d;
      if (adv && end_q) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      ch_q  <= in_i.ch;
      end_q <= in_i.end_of_string;
    end
    if (adv && end_q) res_q <= res_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.error       = res_q.error;
  assign out_o.prefix_bits = res_q.prefix_bits;
  assign out_o.addr_high   = res_q.addr_high;
  assign out_o.addr_low    = res_q.addr_low;
  assign out_o.tail_offset = res_q.tail_offset;
endmodule

// ===== sv/icp_apb_regs.sv =====
// apb configuration registers: allow_tail and cidr_mode
module icp_apb_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output icp_pkg::icp_cfg_t cfg_o
);
  import icp_pkg::*;

  icp_cfg_t cfg_q, cfg_d;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_ALLOW_TAIL: cfg_d.allow_tail = pwdata[0];
        REG_CIDR_MODE:  cfg_d.cidr_mode  = pwdata[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ALLOW_TAIL: prdata = {31'd0, cfg_q.allow_tail};
      REG_CIDR_MODE:  prdata = {31'd0, cfg_q.cidr_mode};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.allow_tail <= 1'b0;
      cfg_q.cidr_mode  <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

// ===== sv/icp_step.sv =====
// one parse step: next state and result for one character or terminator
module icp_step (
  input  icp_pkg::icp_state_t  state_i,
  input  logic [7:0]           ch_i,
  input  logic                 end_i,
  input  icp_pkg::icp_cfg_t    cfg_i,
  output icp_pkg::icp_state_t  state_o,
  output icp_pkg::icp_result_t res_o
);
  import icp_pkg::*;

  icp_state_t s;
  logic [11:0] pos, nxt;
  logic        is_hex, is_dec, is_colon, is_slash;
  logic [3:0]  hex_val;
  logic        do_field;
  logic        fin, fin_ok, fin_at_end, fin_slash;
  logic [7:0]  fin_bits, r;
  logic [11:0] fin_pos;
  logic [AddrBytes-1:0][7:0] src;
  logic [4:0]  nz;
  logic [5:0]  zr_end;
  logic [3:0]  lo_idx;
  logic [10:0] sfx_v;
  logic        err;

  always_comb begin
    is_hex  = 1'b0;
    hex_val = 4'd0;
    if (ch_i >= 8'h30 && ch_i <= 8'h39) begin
      is_hex  = 1'b1;
      hex_val = ch_i[3:0];
    end else if ((ch_i >= 8'h61 && ch_i <= 8'h66) || (ch_i >= 8'h41 && ch_i <= 8'h46)) begin
      is_hex  = 1'b1;
      hex_val = ch_i[3:0] + 4'd9;
    end
    is_dec   = ch_i >= 8'h30 && ch_i <= 8'h39;
    is_colon = ch_i == CH_COLON;
    is_slash = ch_i == CH_SLASH;
  end

  always_comb begin
    s          = state_i;
    pos        = state_i.char_pos;
    nxt        = (pos == POS_MAX) ? pos : pos + 12'd1;
    do_field   = 1'b0;
    fin        = 1'b0;
    fin_ok     = 1'b0;
    fin_bits   = 8'd0;
    fin_at_end = end_i;
    fin_slash  = is_slash;
    fin_pos    = pos;
    r          = ERR_CODE;
    src        = '0;
    nz         = 5'd0;
    zr_end     = 6'd0;
    lo_idx     = 4'd0;
    sfx_v      = 11'd0;

    unique case (state_i.phase)
      PH_START: begin
        if (!end_i && is_colon) begin
          s.phase = PH_START_COLON;
        end else begin
          s.phase  = PH_FIELD;
          do_field = 1'b1;
        end
      end
      PH_START_COLON: begin
        if (!end_i && is_colon) begin
          s.zr_seen  = 1'b1;
          s.zr_start = 5'd0;
          s.phase    = PH_FIELD;
        end else begin
          // lone leading colon: stop at offset zero with a tail
          fin        = 1'b1;
          fin_at_end = 1'b0;
          fin_slash  = 1'b0;
          fin_pos    = 12'd0;
        end
      end
      PH_FIELD: do_field = 1'b1;
      PH_AFTER_COLON: begin
        if (!end_i && is_colon && !state_i.zr_seen) begin
          s.zr_seen  = 1'b1;
          s.zr_start = state_i.byte_count;
          s.phase    = PH_FIELD;
        end else begin
          s.phase  = PH_FIELD;
          do_field = 1'b1;
        end
      end
      PH_SLASH: begin
        if (!end_i && is_dec) begin
          s.suffix = {4'd0, ch_i[3:0]};
          s.phase  = PH_BITS;
        end else begin
          s.prefix_res = ERR_CODE;
          s.stop_pos   = pos;
          s.tail_present = s.tail_present | !end_i;
          s.phase      = PH_DONE;
        end
      end
      PH_BITS: begin
        if (!end_i && is_dec) begin
          sfx_v = {state_i.suffix, 3'd0} + {2'd0, state_i.suffix, 1'b0} + {7'd0, ch_i[3:0]};
          if (sfx_v > {3'd0, BITS_FULL}) begin
            s.prefix_res = ERR_CODE;
            s.stop_pos   = nxt;
            s.phase      = PH_DONE;
          end else begin
            s.suffix = sfx_v[7:0];
          end
        end else begin
          s.prefix_res   = state_i.suffix;
          s.stop_pos     = pos;
          s.tail_present = s.tail_present | !end_i;
          s.phase        = PH_DONE;
        end
      end
      default: begin
        if (!end_i) s.tail_present = 1'b1;
      end
    endcase

    if (do_field) begin
      if (!end_i && is_hex) begin
        if (s.digit_count < 3'd4) begin
          s.field_value = {s.field_value[11:0], hex_val};
          s.digit_count = s.digit_count + 3'd1;
        end else begin
          fin = 1'b1;
        end
      end else if (s.digit_count == 3'd0) begin
        fin = 1'b1;
      end else begin
        s.addr[s.byte_count[3:0]]         = s.field_value[15:8];
        s.addr[s.byte_count[3:0] + 4'd1] = s.field_value[7:0];
        s.byte_count  = s.byte_count + 5'd2;
        s.field_value = 16'd0;
        s.digit_count = 3'd0;
        if (end_i || !is_colon || s.byte_count[4]) begin
          fin      = 1'b1;
          fin_ok   = 1'b1;
          fin_bits = {s.byte_count, 3'd0};
        end else begin
          s.phase = PH_AFTER_COLON;
        end
      end
    end

    if (fin) begin
      if (s.zr_seen) begin
        if (s.byte_count[4]) begin
          r = ERR_CODE;
        end else begin
          // move the bytes after the zero run to the end of the address
          src    = s.addr;
          nz     = 5'd16 - s.byte_count;
          zr_end = {1'b0, s.zr_start} + {1'b0, nz};
          for (int i = 0; i < AddrBytes; i++) begin
            lo_idx = 4'(i) - nz[3:0];
            if (6'(i) < {1'b0, s.zr_start}) s.addr[i] = src[i];
            else if (6'(i) < zr_end) s.addr[i] = 8'd0;
            else s.addr[i] = src[lo_idx];
          end
          r = BITS_FULL;
        end
      end else begin
        r = fin_ok ? fin_bits : ERR_CODE;
      end
      s.prefix_res = r;
      if (cfg_i.cidr_mode && r != ERR_CODE && !fin_at_end && fin_slash) begin
        s.phase = PH_SLASH;
      end else begin
        if (cfg_i.cidr_mode && r == BITS_ONE) s.prefix_res = ERR_CODE;
        s.stop_pos     = fin_pos;
        s.tail_present = s.tail_present | !fin_at_end;
        s.phase        = PH_DONE;
      end
    end

    if (!end_i) s.char_pos = nxt;
  end

  assign err = (s.prefix_res == ERR_CODE) || (!cfg_i.allow_tail && s.tail_present);

  always_comb begin
    res_o.error       = err;
    res_o.prefix_bits = err ? 8'd0 : s.prefix_res;
    res_o.addr_high   = 64'd0;
    res_o.addr_low    = 64'd0;
    if (!err) begin
      // byte 0 lands in the top byte of addr_high
      for (int i = 0; i < AddrBytes/2; i++) begin
        res_o.addr_high[63-8*i -: 8] = s.addr[i];
        res_o.addr_low[63-8*i -: 8]  = s.addr[i+AddrBytes/2];
      end
    end
    res_o.tail_offset = s.stop_pos;
  end

  // per-string state is cleared after the terminator
  assign state_o = end_i ? STATE_CLEAR : s;
endmodule

// ===== test/tb_ipv6_cidr_text_parser.sv =====
// self-checking testbench for the ipv6 cidr text parser: random strings, live prediction, apb setup
module tb_ipv6_cidr_text_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import icp_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
  } char_item_t;

  typedef enum int {LONG_NONE, LONG_SUFFIX, LONG_TAIL} long_kind_e;

  localparam logic [7:0] ChZero = "0";
  localparam logic [7:0] ChNine = "9";
  localparam logic [7:0] ChLowA = "a";
  localparam logic [7:0] ChLowF = "f";
  localparam logic [7:0] ChUpA  = "A";
  localparam logic [7:0] ChUpF  = "F";
  localparam int LongHold = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  icp_in_if  in_ch ();
  icp_out_if out_ch ();

  ipv6_cidr_text_parser DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk_i = ~clk_i;

  char_item_t  char_queue[$];
  icp_result_t expected_results[$];
  logic [7:0]  text_buf[$];

  icp_state_t parser_st;
  icp_cfg_t   cfg;

  bit in_taken;
  int send_gap_pct, recv_gap_pct;
  int send_idle_left, recv_hold_left;
  bit long_hold_done;
  int fail_count, results_checked, error_results, saturated_offsets;
  int random_items, items_queued;

  // ---------------- parser prediction ----------------

  function automatic int hex_digit_value(logic [7:0] c);
    if (c >= ChZero && c <= ChNine) return int'(c - ChZero);
    if (c >= ChLowA && c <= ChLowF) return int'(c - ChLowA) + 10;
    if (c >= ChUpA && c <= ChUpF) return int'(c - ChUpA) + 10;
    return -1;
  endfunction

  function automatic bit is_decimal(logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  function automatic void note_stop(logic [11:0] pos, bit on_char);
    parser_st.stop_pos = pos;
    if (on_char) parser_st.tail_present = 1'b1;
    parser_st.phase = PH_DONE;
  endfunction

  // bytes written after the zero run move to the end of the address
  function automatic void spread_zero_run();
    logic [AddrBytes-1:0][7:0] moved;
    int nz, zs;
    nz = int'(AddrBytes) - int'(parser_st.byte_count);
    zs = int'(parser_st.zr_start);
    for (int i = 0; i < int'(AddrBytes); i++) begin
      if (i < zs) moved[i] = parser_st.addr[i];
      else if (i < zs + nz) moved[i] = 8'd0;
      else moved[i] = parser_st.addr[i - nz];
    end
    parser_st.addr = moved;
  endfunction

  function automatic void close_address(bit ok, int bits, bit at_end, logic [7:0] c,
                                        logic [11:0] pos);
    logic [7:0] r;
    if (parser_st.zr_seen) begin
      if (parser_st.byte_count >= AddrBytes) begin
        r = ERR_CODE;
      end else begin
        spread_zero_run();
        r = BITS_FULL;
      end
    end else begin
      r = ok ? 8'(bits) : ERR_CODE;
    end
    parser_st.prefix_res = r;
    if (cfg.cidr_mode) begin
      if (r != ERR_CODE && !at_end && c == CH_SLASH) begin
        parser_st.phase = PH_SLASH;
        return;
      end
      // a lone 16-bit field needs a suffix in cidr mode
      if (r == BITS_ONE) parser_st.prefix_res = ERR_CODE;
    end
    note_stop(pos, !at_end);
  endfunction

  function automatic void take_field_char(logic [7:0] c, bit at_end, logic [11:0] pos);
    int h, b;
    h = at_end ? -1 : hex_digit_value(c);
    if (h >= 0) begin
      if (parser_st.digit_count < 3'd4) begin
        parser_st.field_value = {parser_st.field_value[11:0], 4'(h)};
        parser_st.digit_count += 3'd1;
      end else begin
        close_address(1'b0, 0, at_end, c, pos);
      end
      return;
    end
    if (parser_st.digit_count == 3'd0) begin
      close_address(1'b0, 0, at_end, c, pos);
      return;
    end
    b = int'(parser_st.byte_count);
    parser_st.addr[b & 15] = parser_st.field_value[15:8];
    parser_st.addr[(b + 1) & 15] = parser_st.field_value[7:0];
    parser_st.byte_count += 5'd2;
    parser_st.field_value = 16'd0;
    parser_st.digit_count = 3'd0;
    if (at_end || c != CH_COLON || parser_st.byte_count >= AddrBytes)
      close_address(1'b1, int'(parser_st.byte_count) * 8, at_end, c, pos);
    else
      parser_st.phase = PH_AFTER_COLON;
  endfunction

  function automatic void parse_item(logic [7:0] c, bit at_end);
    logic [11:0] pos, next;
    logic [63:0] hi, lo;
    logic        err;
    int          v;
    pos = parser_st.char_pos;
    next = (pos < POS_MAX) ? pos + 12'd1 : POS_MAX;
    case (parser_st.phase)
      PH_START: begin
        if (!at_end && c == CH_COLON) begin
          parser_st.phase = PH_START_COLON;
        end else begin
          parser_st.phase = PH_FIELD;
          take_field_char(c, at_end, pos);
        end
      end
      PH_START_COLON: begin
        if (!at_end && c == CH_COLON) begin
          parser_st.zr_seen = 1'b1;
          parser_st.zr_start = 5'd0;
          parser_st.phase = PH_FIELD;
        end else begin
          // single leading colon stops at offset zero
          close_address(1'b0, 0, 1'b0, CH_COLON, 12'd0);
        end
      end
      PH_FIELD: take_field_char(c, at_end, pos);
      PH_AFTER_COLON: begin
        if (!at_end && c == CH_COLON && !parser_st.zr_seen) begin
          parser_st.zr_seen = 1'b1;
          parser_st.zr_start = parser_st.byte_count;
          parser_st.phase = PH_FIELD;
        end else begin
          parser_st.phase = PH_FIELD;
          take_field_char(c, at_end, pos);
        end
      end
      PH_SLASH: begin
        if (!at_end && is_decimal(c)) begin
          parser_st.suffix = c - ChZero;
          parser_st.phase = PH_BITS;
        end else begin
          parser_st.prefix_res = ERR_CODE;
          note_stop(pos, !at_end);
        end
      end
      PH_BITS: begin
        if (!at_end && is_decimal(c)) begin
          v = int'(parser_st.suffix) * 10 + int'(c - ChZero);
          if (v > int'(BITS_FULL)) begin
            parser_st.prefix_res = ERR_CODE;
            note_stop(next, 1'b0);
          end else begin
            parser_st.suffix = 8'(v);
          end
        end else begin
          parser_st.prefix_res = parser_st.suffix;
          note_stop(pos, !at_end);
        end
      end
      default: if (!at_end) parser_st.tail_present = 1'b1;
    endcase

    if (!at_end) begin
      parser_st.char_pos = next;
      return;
    end

    err = (parser_st.prefix_res == ERR_CODE) || (!cfg.allow_tail && parser_st.tail_present);
    hi = '0;
    lo = '0;
    if (!err) begin
      for (int i = 0; i < 8; i++) begin
        hi = {hi[55:0], parser_st.addr[i]};
        lo = {lo[55:0], parser_st.addr[i + 8]};
      end
    end
    expected_results.push_back('{error: err, prefix_bits: err ? 8'd0 : parser_st.prefix_res,
                                 addr_high: hi, addr_low: lo,
                                 tail_offset: parser_st.stop_pos});
    parser_st = STATE_CLEAR;
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // ---------------- channel driver and monitor ----------------

  always @(negedge clk_i) begin : feed_chars
    char_item_t item;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      in_taken = 1'b0;
      if (send_idle_left != 0) begin
        send_idle_left--;
        in_ch.valid <= 1'b0;
      end else if (char_queue.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
        send_idle_left = $urandom_range(1, 14) - 1;
        in_ch.valid <= 1'b0;
      end else begin
        item = char_queue.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.ch <= item.ch;
        in_ch.end_of_string <= item.eos;
      end
    end
  end

  always @(negedge clk_i) begin : drive_ready
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (recv_hold_left != 0) begin
      recv_hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!long_hold_done && results_checked >= 5 && char_queue.size() > 40) begin
      // long stall so terminators back up while characters are still offered
      long_hold_done = 1'b1;
      recv_hold_left = LongHold - 1;
      out_ch.ready <= 1'b0;
    end else if (recv_gap_pct != 0 && $urandom_range(0, 99) < recv_gap_pct) begin
      recv_hold_left = $urandom_range(1, 14) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : watch_channels
    icp_result_t got, want;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        parse_item(in_ch.ch, in_ch.end_of_string);
        in_taken = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{error: out_ch.error, prefix_bits: out_ch.prefix_bits,
                addr_high: out_ch.addr_high, addr_low: out_ch.addr_low,
                tail_offset: out_ch.tail_offset};
        if (expected_results.size() == 0) begin
          $error("result transfer with no terminator pending");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (want.error) error_results++;
          if (want.tail_offset == POS_MAX) saturated_offsets++;
          compare_field("error", 64'(want.error), 64'(got.error));
          compare_field("prefix_bits", 64'(want.prefix_bits), 64'(got.prefix_bits));
          compare_field("addr_high", want.addr_high, got.addr_high);
          compare_field("addr_low", want.addr_low, got.addr_low);
          compare_field("tail_offset", 64'(want.tail_offset), 64'(got.tail_offset));
        end
      end
    end
  end

  // ---------------- string builders ----------------

  function automatic logic [7:0] pick_char(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  function automatic void put_field(int ndig);
    int v;
    for (int i = 0; i < ndig; i++) begin
      v = $urandom_range(0, 15);
      if (v < 10) text_buf.push_back(ChZero + 8'(v));
      else text_buf.push_back(($urandom_range(0, 1) ? ChLowA : ChUpA) + 8'(v - 10));
    end
  endfunction

  function automatic void finish_string(bit counted);
    foreach (text_buf[i]) char_queue.push_back('{ch: text_buf[i], eos: 1'b0});
    // the character on a terminator is ignored, so it carries random bits
    char_queue.push_back('{ch: 8'($urandom_range(0, 255)), eos: 1'b1});
    items_queued += text_buf.size() + 1;
    if (counted) random_items += text_buf.size() + 1;
    text_buf.delete();
  endfunction

  function automatic void build_address();
    int nfields, zpos;
    bit zrun;
    nfields = $urandom_range(0, 8);
    zrun = ($urandom_range(0, 2) == 0);
    zpos = $urandom_range(0, nfields);
    for (int i = 0; i <= nfields; i++) begin
      if (zrun && i == zpos) begin
        text_buf.push_back(CH_COLON);
        text_buf.push_back(CH_COLON);
      end else if (i > 0 && i < nfields) begin
        text_buf.push_back(CH_COLON);
      end
      // now and then a field with one digit too many
      if (i < nfields) put_field(($urandom_range(0, 19) == 0) ? 5 : $urandom_range(1, 4));
    end
  endfunction

  function automatic void build_suffix();
    text_buf.push_back(CH_SLASH);
    case ($urandom_range(0, 9))
      0: ;
      1: push_text($sformatf("%0d", $urandom_range(129, 999)));
      2: push_text($sformatf("00%0d", $urandom_range(0, 140)));
      default: push_text($sformatf("%0d", $urandom_range(0, 128)));
    endcase
  endfunction

  function automatic void build_random_string();
    int kind, n, p;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      n = $urandom_range(0, 6);
      repeat (n) begin
        if ($urandom_range(0, 1)) text_buf.push_back(8'($urandom_range(0, 255)));
        else text_buf.push_back(pick_char("::/0aF"));
      end
    end else begin
      build_address();
      if ($urandom_range(0, 1)) build_suffix();
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 5);
        repeat (n) text_buf.push_back(($urandom_range(0, 1)) ? 8'($urandom_range(0, 255))
                                                             : pick_char(":/1x "));
      end
      if (kind < 25 && text_buf.size() != 0) begin
        p = $urandom_range(0, text_buf.size() - 1);
        if ($urandom_range(0, 2) == 0) begin
          // extra double colon somewhere in the string
          text_buf.insert(p, CH_COLON);
          text_buf.insert(p, CH_COLON);
        end else begin
          text_buf[p] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                     : pick_char(":/g");
        end
      end
    end
    finish_string(1'b1);
  endfunction

  function automatic void queue_random(int n);
    int start;
    start = random_items;
    while (random_items - start < n) build_random_string();
  endfunction

  function automatic void queue_long(long_kind_e kind);
    if (kind == LONG_SUFFIX) begin
      // leading zeros keep the suffix open past the offset limit
      push_text("::/");
      repeat ($urandom_range(4090, 4100)) text_buf.push_back(ChZero);
      finish_string(1'b0);
    end else if (kind == LONG_TAIL) begin
      push_text("a::b");
      repeat ($urandom_range(4090, 4105)) text_buf.push_back(8'($urandom_range(0, 255)));
      finish_string(1'b0);
    end
  endfunction

  // ---------------- sequencing ----------------

  task automatic wait_idle();
    while (char_queue.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_register(logic reg_idx, logic value);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {reg_idx, 2'b00};
    pwdata = {31'd0, value};
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    if (reg_idx == REG_ALLOW_TAIL) cfg.allow_tail = value;
    else cfg.cidr_mode = value;
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    compare_field(reg_idx == REG_ALLOW_TAIL ? "allow_tail readback" : "cidr_mode readback",
                  64'({31'd0, value}), 64'(prdata));
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic run_phase(logic tail, logic cidr, int n, int sgap, int rgap,
                           long_kind_e long_kind);
    wait_idle();
    set_register(REG_ALLOW_TAIL, tail);
    set_register(REG_CIDR_MODE, cidr);
    send_gap_pct = sgap;
    recv_gap_pct = rgap;
    queue_random(n / 2);
    queue_long(long_kind);
    // sender holds back until every pending result is in
    wait_idle();
    queue_random(n - n / 2);
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.ch = '0;
    in_ch.end_of_string = 1'b0;
    out_ch.ready = 1'b0;
    parser_st = STATE_CLEAR;
    cfg = '{allow_tail: 1'b0, cidr_mode: 1'b1};
    send_gap_pct = 10;
    recv_gap_pct = 10;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed strings under the reset settings
    push_text(":1");    finish_string(1'b0);
    push_text("::");    finish_string(1'b0);
    push_text("12345"); finish_string(1'b0);
    push_text("F");     finish_string(1'b0);
    text_buf.push_back(8'h00); finish_string(1'b0);
    text_buf.push_back(8'hFF); finish_string(1'b0);
    push_text("0::/");  finish_string(1'b0);
    queue_random(200);

    run_phase(1'b1, 1'b1, 220, 5, 20, LONG_SUFFIX);
    run_phase(1'b0, 1'b0, 220, 20, 5, LONG_NONE);
    run_phase(1'b1, 1'b0, 220, 8, 8, LONG_NONE);
    run_phase(1'b0, 1'b1, 200, 0, 0, LONG_NONE);

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("summary: %0d strings checked across five configuration phases, %0d of them errors",
             results_checked, error_results);
    $display("summary: %0d characters sent, %0d results with a saturated offset",
             items_queued, saturated_offsets);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #3ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
